// ===== src/jrt_pkg.sv =====
package jrt_pkg;

	localparam int unsigned TABLE_ENTRIES = 64;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_CHECK = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic REG_REPLAY_TAIL = 1'b0;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] block_number;
		logic [31:0] log_position;
	} request_t;

	typedef struct packed {
		logic inserted_new;
		logic revoked;
		logic table_full;
	} result_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic        act;
		logic        hit;
		logic [31:0] hit_pos;
		logic        free_found;
	} token_t;

	// write-back broadcast to every cell once the search is finished
	typedef struct packed {
		logic        update;
		logic        insert;
		logic        clear;
		logic [63:0] block;
		logic [31:0] position;
	} commit_t;

endpackage

// ===== src/jrt_cell.sv =====
module jrt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [63:0]      key,
	input  jrt_pkg::token_t  token_in,
	output jrt_pkg::token_t  token_out,
	input  jrt_pkg::commit_t commit
);

	logic             valid_q;
	logic [63:0]      block_q;
	logic [31:0]      pos_q;
	logic             hit_q;
	logic             claim_q;
	jrt_pkg::token_t  token_q;
	logic             match;
	logic             free;

	assign match     = valid_q && (block_q == key);
	assign free      = !valid_q;
	assign token_out = token_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
			claim_q <= 1'b0;
			token_q <= '0;
		end else begin
			token_q <= '{
				act:        token_in.act,
				hit:        token_in.hit | match,
				hit_pos:    match ? pos_q : token_in.hit_pos,
				free_found: token_in.free_found | free
			};
			if (token_in.act) begin
				hit_q   <= match;
				claim_q <= free && !token_in.free_found;
			end
			if (commit.clear) begin
				valid_q <= 1'b0;
			end else if (commit.insert && claim_q) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit.insert && claim_q && !commit.clear) begin
			block_q <= commit.block;
			pos_q   <= commit.position;
		end else if (commit.update && hit_q) begin
			pos_q <= commit.position;
		end
	end

endmodule

// ===== src/journal_revoke_table_core.sv =====
// Revoke table for journal replay: a chain of TABLE_ENTRIES cells, each holding
// one block number with the log position at which it was revoked.
// Request channel: request (command, block_number, log_position) is taken at a
// rising edge where start is high and busy is low. One transaction is in
// flight at a time; busy stays high until it has fully completed.
// Result channel: result (inserted_new, revoked, table_full) is shown for one
// cycle with done high; it cannot be held off and must be taken that cycle.
// Search: a search token walks the chain one cell per cycle, and done is
// registered from the token as it leaves the last cell; the result is taken
// at the next edge. The write-back lands on that same edge and busy drops, so
// a new request is accepted only after the previous one has fully completed.
// Configuration: APB port, replay_tail at byte address 0. The user must write
// it only while idle, which the block does not enforce. pready is always high.
// Reset: the table is empty, replay_tail is 0 and the block is idle at once.
module journal_revoke_table_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  jrt_pkg::request_t request,
	output logic              done,
	output jrt_pkg::result_t  result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_COMMIT
	} state_t;

	state_t            state_q;
	logic [31:0]       replay_tail_q;
	jrt_pkg::request_t req_q;
	logic              launch_q;
	logic              done_q;
	jrt_pkg::result_t  result_q;
	jrt_pkg::commit_t  commit_q;
	jrt_pkg::token_t   chain [jrt_pkg::TABLE_ENTRIES + 1];
	jrt_pkg::token_t   tail;
	logic              accept;
	logic              search_done;
	logic              wrapped;
	logic              after_tail;
	logic              before_stored;
	logic              rev;
	jrt_pkg::result_t  result_d;
	jrt_pkg::commit_t  commit_d;

	assign accept      = start && (state_q == ST_IDLE);
	assign search_done = (state_q == ST_RUN) && tail.act;
	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign result      = result_q;
	assign pready      = 1'b1;
	assign prdata = (paddr[2] == jrt_pkg::REG_REPLAY_TAIL) ? replay_tail_q : 32'd0;

	assign chain[0] = '{act: launch_q, hit: 1'b0, hit_pos: 32'd0, free_found: 1'b0};
	assign tail     = chain[jrt_pkg::TABLE_ENTRIES];

	for (genvar i = 0; i < jrt_pkg::TABLE_ENTRIES; i++) begin : g_cell
		jrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (req_q.block_number),
			.token_in (chain[i]),
			.token_out(chain[i + 1]),
			.commit   (commit_q)
		);
	end

	assign wrapped       = tail.hit_pos < replay_tail_q;
	assign after_tail    = replay_tail_q < req_q.log_position;
	assign before_stored = req_q.log_position < tail.hit_pos;
	assign rev = tail.hit && (wrapped ? (after_tail || before_stored)
	                                  : (after_tail && before_stored));

	always_comb begin
		result_d          = '0;
		commit_d          = '0;
		commit_d.block    = req_q.block_number;
		commit_d.position = req_q.log_position;
		case (req_q.command)
			jrt_pkg::CMD_ADD: begin
				if (tail.hit) begin
					commit_d.update = 1'b1;
				end else if (tail.free_found) begin
					commit_d.insert       = 1'b1;
					result_d.inserted_new = 1'b1;
				end else begin
					result_d.table_full = 1'b1;
				end
			end
			jrt_pkg::CMD_CHECK: begin
				result_d.revoked = rev;
			end
			jrt_pkg::CMD_CLEAR: begin
				commit_d.clear = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replay_tail_q <= 32'd0;
		end else if (psel && penable && pwrite && pready
		             && paddr[2] == jrt_pkg::REG_REPLAY_TAIL) begin
			replay_tail_q <= pwdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
			commit_q <= '0;
		end else begin
			launch_q <= accept;
			done_q   <= search_done;
			commit_q <= search_done ? commit_d : '0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (tail.act) begin
						result_q <= result_d;
						state_q  <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
